### hdl/lin_frame_checksum_receiver_assert.svh
// -----------------------------------------------------------------------------
// LIN frame receiver assertion macros
// Shared property forms used by the receiver's concurrent checks.
// -----------------------------------------------------------------------------
`ifndef LIN_FRAME_CHECKSUM_RECEIVER_ASSERT_SVH
`define LIN_FRAME_CHECKSUM_RECEIVER_ASSERT_SVH

// a implies b in the same cycle
`define LFCR_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("same-cycle implication violated");

// a implies b in the next cycle
`define LFCR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle implication violated");

`endif

### hdl/lfcr_pkg.sv
// -----------------------------------------------------------------------------
// LIN frame receiver package
// Frame geometry constants and the request structs between front, buffer
// and drain.
// -----------------------------------------------------------------------------
package lfcr_pkg;

    localparam int FRAME_BYTES = 15;
    localparam int PAYLOAD_LEN = FRAME_BYTES - 2;
    localparam int LAST_POS    = FRAME_BYTES - 1;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int IDX_W       = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;

    localparam logic [7:0] ID_RESET = 8'h04;

    // front -> buffer: payload write and frame commit
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic             push;
    } t_wr_req;

    // drain -> buffer: payload read and bank release
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             pop;
    } t_rd_req;

endpackage

### hdl/lfcr_front.sv
// -----------------------------------------------------------------------------
// LIN frame receiver front end
// Counts bytes into frames, checks the identifier, accumulates the classic
// checksum and writes payload bytes into the buffer's tail bank.
// -----------------------------------------------------------------------------
module lfcr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_expected_id,
    input  logic              i_tail_busy,
    output lfcr_pkg::t_wr_req o_wr
);
    import lfcr_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic             r_id_ok, n_id_ok;
    logic [7:0]       r_expected_id;

    logic             is_payload;
    logic             is_last;
    logic             accept;
    logic [8:0]       sum_wide;
    logic [POS_W-1:0] pos_m1;

    assign is_payload = (r_pos != '0) && (r_pos < POS_W'(LAST_POS));
    assign is_last    = (r_pos == POS_W'(LAST_POS));
    // hold the link while the bank this payload would land in still drains
    assign o_rx_stall = is_payload && i_tail_busy;
    assign accept     = i_rx_valid && !o_rx_stall;

    // end-around carry: subtracting 255 past 255 is the carry folded back in
    assign sum_wide = {1'b0, r_sum} + {1'b0, i_rx_byte};
    assign pos_m1   = r_pos - POS_W'(1);

    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_id_ok = r_id_ok;
        o_wr.en   = 1'b0;
        o_wr.idx  = IDX_W'(pos_m1);
        o_wr.data = i_rx_byte;
        o_wr.push = 1'b0;
        if (accept) begin
            if (r_pos == '0) begin
                n_id_ok = (i_rx_byte == r_expected_id);
                n_sum   = '0;
                n_pos   = POS_W'(1);
            end else if (is_last) begin
                o_wr.push = r_id_ok && (i_rx_byte == ~r_sum);
                n_pos     = '0;
                n_sum     = '0;
                n_id_ok   = 1'b0;
            end else begin
                o_wr.en = 1'b1;
                n_sum   = sum_wide[7:0] + {7'd0, sum_wide[8]};
                n_pos   = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_sum         <= '0;
            r_id_ok       <= 1'b0;
            r_expected_id <= ID_RESET;
        end else begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_id_ok <= n_id_ok;
            if (i_cfg_valid) begin
                r_expected_id <= i_cfg_expected_id;
            end
        end
    end

endmodule

### hdl/lfcr_buf.sv
// -----------------------------------------------------------------------------
// LIN frame receiver payload buffer
// Two payload banks used as a two-entry queue of accepted frames: the front
// fills the tail bank, the drain reads the head bank.
// -----------------------------------------------------------------------------
module lfcr_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfcr_pkg::t_wr_req i_wr,
    input  lfcr_pkg::t_rd_req i_rd,
    output logic              o_tail_busy,
    output logic              o_head_busy,
    output logic [7:0]        o_rdata
);
    import lfcr_pkg::*;

    logic [7:0] r_mem [2][PAYLOAD_LEN];
    logic [7:0] r_rdata;
    logic [1:0] r_busy, n_busy;
    logic       r_tail;
    logic       r_head;

    assign o_tail_busy = r_busy[r_tail];
    assign o_head_busy = r_busy[r_head];
    assign o_rdata     = r_rdata;

    always_comb begin
        n_busy = r_busy;
        if (i_wr.push) begin
            n_busy[r_tail] = 1'b1;
        end
        if (i_rd.pop) begin
            n_busy[r_head] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[r_tail][i_wr.idx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[r_head][i_rd.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            r_tail <= 1'b0;
            r_head <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (i_wr.push) begin
                r_tail <= ~r_tail;
            end
            if (i_rd.pop) begin
                r_head <= ~r_head;
            end
        end
    end

endmodule

### hdl/lfcr_drain.sv
// -----------------------------------------------------------------------------
// LIN frame receiver drain
// Reads the head bank one payload byte a cycle into the output register while
// not stalled, tags index and last flag, frees the bank after its last byte.
// -----------------------------------------------------------------------------
module lfcr_drain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_busy,
    input  logic [7:0]        i_rdata,
    output lfcr_pkg::t_rd_req o_rd,
    output logic              o_payload_valid,
    input  logic              i_payload_stall,
    output logic [7:0]        o_payload_byte,
    output logic [3:0]        o_payload_index,
    output logic              o_last_byte
);
    import lfcr_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [3:0]       r_index;
    logic             r_last;
    logic             advance;
    logic             idx_last;

    // the buffer's read register doubles as the output data register
    assign advance  = !r_valid || !i_payload_stall;
    assign idx_last = (r_idx == IDX_W'(PAYLOAD_LEN - 1));

    assign o_rd.en  = advance && i_head_busy;
    assign o_rd.idx = r_idx;
    assign o_rd.pop = o_rd.en && idx_last;

    assign o_payload_valid = r_valid;
    assign o_payload_byte  = i_rdata;
    assign o_payload_index = r_index;
    assign o_last_byte     = r_last;

    always_ff @(posedge i_clk) begin
        if (o_rd.en) begin
            r_index <= 4'(r_idx);
            r_last  <= idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= o_rd.en;
            if (o_rd.en) begin
                r_idx <= idx_last ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

endmodule

### hdl/lin_frame_checksum_receiver.sv
// -----------------------------------------------------------------------------
// LIN frame checksum receiver
// Frames received bytes, checks identifier and classic checksum, and bursts
// out the payload of each good frame.
// -----------------------------------------------------------------------------
// Bytes are taken one per cycle and grouped into fixed frames counted from
// reset; byte 0 is checked against expected_id, the payload bytes are summed
// with end-around carry, and the last byte must be the inverted sum. A good
// frame's payload comes out in order, one byte a cycle unless the output stalls,
// after its checksum byte is taken; bad frames give nothing. Payload sits in
// two banks, so the next frame is received while the previous one drains. The
// input stalls only when a payload byte would land in a bank whose frame has
// not yet been fully read out, i.e. when one accepted frame is still draining
// and a second one waits behind it. Configuration writes are always ready.
// -----------------------------------------------------------------------------
module lin_frame_checksum_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_expected_id,
    output logic       o_payload_valid,
    input  logic       i_payload_stall,
    output logic [7:0] o_payload_byte,
    output logic [3:0] o_payload_index,
    output logic       o_last_byte
);
    import lfcr_pkg::*;
    `include "lin_frame_checksum_receiver_assert.svh"

    t_wr_req    wr;
    t_rd_req    rd;
    logic       tail_busy;
    logic       head_busy;
    logic [7:0] rdata;

    assign o_cfg_ready = 1'b1;

    lfcr_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (i_rx_valid),
        .o_rx_stall        (o_rx_stall),
        .i_rx_byte         (i_rx_byte),
        .i_cfg_valid       (i_cfg_valid && o_cfg_ready),
        .i_cfg_expected_id (i_cfg_expected_id),
        .i_tail_busy       (tail_busy),
        .o_wr              (wr)
    );

    lfcr_buf u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_rd        (rd),
        .o_tail_busy (tail_busy),
        .o_head_busy (head_busy),
        .o_rdata     (rdata)
    );

    lfcr_drain u_drain (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_busy     (head_busy),
        .i_rdata         (rdata),
        .o_rd            (rd),
        .o_payload_valid (o_payload_valid),
        .i_payload_stall (i_payload_stall),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_last_byte     (o_last_byte)
    );

    // never overwrite a bank that still waits to drain
    `LFCR_ASSERT_IMPLY(a_wr_free_bank, i_clk, i_rst_n, wr.en, !tail_busy)
    // never read a bank that holds no accepted frame
    `LFCR_ASSERT_IMPLY(a_rd_full_bank, i_clk, i_rst_n, rd.en, head_busy)
    // a read always lands a beat in the output register
    `LFCR_ASSERT_NEXT(a_rd_to_out, i_clk, i_rst_n, rd.en, o_payload_valid)

endmodule

### test/lin_frame_checksum_receiver_test.sv
// -----------------------------------------------------------------------------
// LIN frame checksum receiver testbench
// Streams framed bytes into the receiver, rebuilds each frame's verdict and
// payload burst alongside it, and checks every payload beat in order. A short
// stimulus table comes first, then random frames, mostly well formed, with
// random gaps on the input, random and long stalls on the output, and
// identifier writes between phases.
// -----------------------------------------------------------------------------
module lin_frame_checksum_receiver_test;
    import lfcr_pkg::*;

    typedef enum logic [1:0] {V_PREDICT, V_ACCEPT, V_DROP} t_verdict;
    typedef enum logic {R_RX, R_CFG} t_row_kind;
    typedef enum logic [1:0] {FK_GOOD, FK_BAD_ID, FK_BAD_SUM, FK_NOISE} t_frame_kind;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] index;
        logic       last;
    } t_payload_beat;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] value;
        t_verdict   verdict;
    } t_stim_row;

    localparam int IDLE_PCT     = 13;
    localparam int DRAIN_WAIT   = 20;
    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 80;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_rx_valid;
    logic       o_rx_stall;
    logic [7:0] i_rx_byte;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_expected_id;
    logic       o_payload_valid;
    logic       i_payload_stall;
    logic [7:0] o_payload_byte;
    logic [3:0] o_payload_index;
    logic       o_last_byte;

    // frame tracker state
    logic [7:0]    cur_id;
    int            frm_pos;
    logic [7:0]    frm_sum;
    logic          frm_id_ok;
    logic [7:0]    frm_store [PAYLOAD_LEN];

    t_payload_beat burst_q[$];
    t_payload_beat payload_due[$];
    t_payload_beat typed_q[$];
    t_payload_beat beat_want;
    t_stim_row     dir_rows[$];

    t_frame_kind   gen_kind;
    logic          calm;
    logic          force_good;
    logic          hold_go;
    int            hold_left;

    int            fails;
    int            rx_count;
    int            cfg_count;
    int            frames_ok;
    int            beats_seen;
    int            holds_done;
    int            quiet;

    lin_frame_checksum_receiver u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (i_rx_valid),
        .o_rx_stall        (o_rx_stall),
        .i_rx_byte         (i_rx_byte),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_expected_id (i_cfg_expected_id),
        .o_payload_valid   (o_payload_valid),
        .i_payload_stall   (i_payload_stall),
        .o_payload_byte    (o_payload_byte),
        .o_payload_index   (o_payload_index),
        .o_last_byte       (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_payload_beat make_beat(logic [7:0] data, int idx, logic last);
        t_payload_beat beat;
        beat.data  = data;
        beat.index = idx[3:0];
        beat.last  = last;
        return beat;
    endfunction

    function automatic void add_row(t_row_kind kind, logic [7:0] value, t_verdict verdict);
        t_stim_row row;
        row.kind    = kind;
        row.value   = value;
        row.verdict = verdict;
        dir_rows.push_back(row);
    endfunction

    // Advance the frame tracker by one byte; a good checksum byte fills burst_q.
    task automatic frame_step(input logic [7:0] b);
        logic [8:0] s;
        int         k;
        burst_q.delete();
        if (frm_pos == 0) begin
            frm_id_ok = (b == cur_id);
            frm_sum   = 8'h00;
            frm_pos   = 1;
        end else if (frm_pos < LAST_POS) begin
            s = {1'b0, frm_sum} + {1'b0, b};
            if (s > 9'h0FF)
                s = s - 9'h0FF;
            frm_sum = s[7:0];
            frm_store[frm_pos - 1] = b;
            frm_pos++;
        end else begin
            if (frm_id_ok && b == 8'(~frm_sum)) begin
                for (k = 0; k < PAYLOAD_LEN; k++)
                    burst_q.push_back(make_beat(frm_store[k], k, k == PAYLOAD_LEN - 1));
                frames_ok++;
            end
            frm_pos   = 0;
            frm_sum   = 8'h00;
            frm_id_ok = 1'b0;
        end
    endtask

    // Pick the next byte of the stream; the frame kind is drawn at byte 0.
    function automatic logic [7:0] next_rx_byte();
        logic [7:0] v;
        int         r;
        if (frm_pos == 0) begin
            r = $urandom_range(99);
            if (force_good || r < 60)
                gen_kind = FK_GOOD;
            else if (r < 75)
                gen_kind = FK_BAD_ID;
            else if (r < 90)
                gen_kind = FK_BAD_SUM;
            else
                gen_kind = FK_NOISE;
        end
        r = $urandom_range(9);
        v = (r < 2) ? 8'h00 : (r < 4) ? 8'hFF : 8'($urandom);
        if (gen_kind != FK_NOISE) begin
            if (frm_pos == 0)
                v = (gen_kind == FK_BAD_ID) ? cur_id ^ 8'($urandom_range(1, 255)) : cur_id;
            else if (frm_pos == LAST_POS)
                v = (gen_kind == FK_BAD_SUM) ? ~frm_sum ^ 8'($urandom_range(1, 255))
                                             : ~frm_sum;
        end
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_rx(input logic [7:0] b, input t_verdict v);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall)
            @(posedge i_clk);
        frame_step(b);
        rx_count++;
        if (v == V_PREDICT) begin
            foreach (burst_q[k])
                payload_due.push_back(burst_q[k]);
        end else if (v == V_ACCEPT) begin
            foreach (typed_q[k])
                payload_due.push_back(typed_q[k]);
        end
        @(negedge i_clk);
    endtask

    // Write the identifier once the output has drained and the pipeline settled.
    task automatic write_id(input logic [7:0] id);
        i_rx_valid <= 1'b0;
        while (payload_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_expected_id <= id;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cur_id = id;
        cfg_count++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // output side: random stalls, plus one long hold on request
    initial begin
        i_payload_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_payload_stall <= 1'b1;
            end else begin
                i_payload_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_payload_valid === 1'b1 && !i_payload_stall) begin
            beats_seen++;
            if (payload_due.size() == 0) begin
                $display("%0t: payload beat expected none got byte %h index %0d last %b",
                         $time, o_payload_byte, o_payload_index, o_last_byte);
                fails++;
            end else begin
                beat_want = payload_due.pop_front();
                if (o_payload_byte !== beat_want.data) begin
                    $display("%0t: payload_byte expected %h got %h",
                             $time, beat_want.data, o_payload_byte);
                    fails++;
                end
                if (o_payload_index !== beat_want.index) begin
                    $display("%0t: payload_index expected %0d got %0d",
                             $time, beat_want.index, o_payload_index);
                    fails++;
                end
                if (o_last_byte !== beat_want.last) begin
                    $display("%0t: last_byte expected %b got %b",
                             $time, beat_want.last, o_last_byte);
                    fails++;
                end
            end
        end
    end

    // watchdog: count cycles in which no beat moves on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && !o_rx_stall) || (o_payload_valid && !i_payload_stall)
            || (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d payload beats still due",
                     $time, quiet, payload_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : main
        int i;
        int k;
        int n;
        int phase;
        int rand_items;

        i_rst_n           = 1'b0;
        i_rx_valid        = 1'b0;
        i_rx_byte         = 8'h00;
        i_cfg_valid       = 1'b0;
        i_cfg_expected_id = 8'h00;
        cur_id     = ID_RESET;
        frm_pos    = 0;
        frm_sum    = 8'h00;
        frm_id_ok  = 1'b0;
        gen_kind   = FK_GOOD;
        calm       = 1'b0;
        force_good = 1'b0;
        hold_go    = 1'b0;
        fails      = 0;
        rx_count   = 0;
        cfg_count  = 0;
        frames_ok  = 0;
        beats_seen = 0;
        holds_done = 0;
        quiet      = 0;
        rand_items = 0;

        // good frame under the reset identifier, payload at the byte extremes
        add_row(R_RX, ID_RESET, V_PREDICT);
        add_row(R_RX, 8'hFF, V_PREDICT);
        add_row(R_RX, 8'hFF, V_PREDICT);
        add_row(R_RX, 8'h00, V_PREDICT);
        add_row(R_RX, 8'h01, V_PREDICT);
        add_row(R_RX, 8'h80, V_PREDICT);
        add_row(R_RX, 8'h7F, V_PREDICT);
        for (k = 0; k < PAYLOAD_LEN - 6; k++)
            add_row(R_RX, 8'h00, V_PREDICT);
        add_row(R_RX, 8'hFE, V_ACCEPT);
        // wrong identifier, then the identifier rewritten mid-frame to the one
        // sent; the checksum is right but the frame must still be dropped
        add_row(R_CFG, 8'hFF, V_PREDICT);
        add_row(R_RX, ID_RESET, V_PREDICT);
        add_row(R_CFG, ID_RESET, V_PREDICT);
        for (k = 1; k <= PAYLOAD_LEN; k++)
            add_row(R_RX, 8'(k), V_PREDICT);
        add_row(R_RX, 8'hA4, V_DROP);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (i = 0; i < dir_rows.size(); i++) begin
            if (dir_rows[i].kind == R_CFG) begin
                write_id(dir_rows[i].value);
            end else begin
                if (dir_rows[i].verdict == V_ACCEPT) begin
                    typed_q.delete();
                    for (k = 0; k < PAYLOAD_LEN; k++)
                        typed_q.push_back(make_beat(dir_rows[i - PAYLOAD_LEN + k].value, k,
                                                    k == PAYLOAD_LEN - 1));
                end
                send_rx(dir_rows[i].value, dir_rows[i].verdict);
            end
        end

        phase = 0;
        while (rand_items < RANDOM_ITEMS) begin
            case (phase)
                0: write_id(8'h00);
                1: write_id(8'hFF);
                default: begin
                    if ($urandom_range(1) == 1)
                        write_id(8'($urandom_range(255)));
                end
            endcase
            calm       = (phase == 3);
            force_good = (phase == 1);
            if (phase == 1) begin
                // finish the open frame, then three good ones against a held output
                n = (FRAME_BYTES - frm_pos) % FRAME_BYTES + 3 * FRAME_BYTES;
                hold_go = 1'b1;
            end else if (phase == 3) begin
                n = 2 * FRAME_BYTES;
            end else begin
                n = $urandom_range(4, 12);
            end
            repeat (n) begin
                send_rx(next_rx_byte(), V_PREDICT);
                rand_items++;
            end
            phase++;
        end
        calm       = 1'b0;
        force_good = 1'b0;

        i_rx_valid <= 1'b0;
        while (payload_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d received bytes, %0d identifier writes, %0d good frames",
                 rx_count, cfg_count, frames_ok);
        $display("%0d payload beats checked across %0d long output hold(s)",
                 beats_seen, holds_done);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/lfcr_pkg.sv
hdl/lfcr_front.sv
hdl/lfcr_buf.sv
hdl/lfcr_drain.sv
hdl/lin_frame_checksum_receiver.sv
test/lin_frame_checksum_receiver_test.sv
